// ===== hdl/pvf_pkg.sv =====
// ----------------------------------------------------------------------------
// pvf_pkg
// Shared constants for the parabola vertex/focus core and its multiplier.
// ----------------------------------------------------------------------------
package pvf_pkg;

   localparam int LIMB_WIDTH  = 32;
   localparam int MUL_LATENCY = 3;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic CSR_REG_AXIS_MIN_SQ = 1'b0;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DEGEN     = 2'd1;
   localparam logic [1:0] STATUS_AT_VERTEX = 2'd2;
   localparam logic [1:0] STATUS_SAT       = 2'd3;

endpackage

// ===== hdl/pvf_mul.sv =====
// ----------------------------------------------------------------------------
// pvf_mul
// Pipelined unsigned multiplier built from 32x32 limb products, registered as partial products, row sums and final sum.
// ----------------------------------------------------------------------------
module pvf_mul import pvf_pkg::*; #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [A_WIDTH-1:0]         a,
   input  logic [B_WIDTH-1:0]         b,
   output logic [A_WIDTH+B_WIDTH-1:0] prod
);

   localparam int NA = (A_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int NB = (B_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int PW = A_WIDTH + B_WIDTH;

   logic [NA*LIMB_WIDTH-1:0] a_pad;
   logic [NB*LIMB_WIDTH-1:0] b_pad;
   logic [2*LIMB_WIDTH-1:0]  part_ff [NA][NB];
   logic [PW-1:0]            row_in  [NA];
   logic [PW-1:0]            row_ff  [NA];
   logic [PW-1:0]            prod_in;
   logic [PW-1:0]            prod_ff;

   assign a_pad = (NA*LIMB_WIDTH)'(a);
   assign b_pad = (NB*LIMB_WIDTH)'(b);

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (PW'(part_ff[i][j]) << (j*LIMB_WIDTH));
         end
      end
      prod_in = '0;
      for (int i = 0; i < NA; i++) begin
         prod_in = prod_in + (row_ff[i] << (i*LIMB_WIDTH));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               part_ff[i][j] <= a_pad[i*LIMB_WIDTH +: LIMB_WIDTH]
                              * b_pad[j*LIMB_WIDTH +: LIMB_WIDTH];
            end
         end
         row_ff  <= row_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/parabola_vertex_focus_from_bezier_core.sv =====
// ----------------------------------------------------------------------------
// parabola_vertex_focus_from_bezier_core
// Vertex and focus of the parabola through a quadratic Bezier, exact rational
// math, one rounding, saturation to COORD_WIDTH.
// ----------------------------------------------------------------------------
//  port group | dir | handshake       | word
//  req_*      | in  | valid / stall   | start, mid, end control points
//  rsp_*      | out | valid / stall   | vertex, focus, status
//  p*         | in  | APB write/read  | axis_min_sq at byte address 0
//
//  One word per cycle sustained while the output is not stalled. The path is
//  six arithmetic stages, three multiplier banks, a restoring divider of
//  COORD_WIDTH + 1 stages (entry, then one quotient bit per stage), a
//  rounding stage and the output register.
//  Synchronous reset clears valid bits and sets axis_min_sq to 1.
//  A stalled output freezes the whole pipeline; req_stall follows it.
// ----------------------------------------------------------------------------
module parabola_vertex_focus_from_bezier_core import pvf_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_mid_x,
   input  logic signed [COORD_WIDTH-1:0] req_mid_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_vertex_x,
   output logic signed [COORD_WIDTH-1:0] rsp_vertex_y,
   output logic signed [COORD_WIDTH-1:0] rsp_focus_x,
   output logic signed [COORD_WIDTH-1:0] rsp_focus_y,
   output logic [1:0]                    rsp_status,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int W   = COORD_WIDTH;
   localparam int CW1 = W + 1;
   localparam int DWS = W + 3;
   localparam int MCW = W;
   localparam int MDW = W + 2;
   localparam int PS  = 2*W + 4;
   localparam int PW  = 2*W + 3;
   localparam int QW  = 2*W + 5;
   localparam int KW  = 2*W + 1;
   localparam int AS  = 2*W + 6;
   localparam int US  = 3*W + 8;
   localparam int UW  = 3*W + 7;
   localparam int FS  = 3*W + 6;
   localparam int FW  = 3*W + 5;
   localparam int VW  = PW + UW;
   localparam int DEN = 2*QW;
   localparam int NWD = 5*W + 11;
   localparam int FV  = W + 3;
   localparam int TW  = ((QW + 32) > (2*FRAC_BITS + 34)) ? (QW + 32) : (2*FRAC_BITS + 34);
   localparam int NL  = 4;

   localparam logic signed [FV-1:0] SAT_HI = (FV'(1) <<< (W-1)) - FV'(1);
   localparam logic signed [FV-1:0] SAT_LO = -(FV'(1) <<< (W-1));

   typedef struct packed {
      logic                  vld;
      logic signed [W-1:0]   sx;
      logic signed [W-1:0]   sy;
      logic signed [CW1-1:0] c1x;
      logic signed [CW1-1:0] c1y;
      logic signed [DWS-1:0] dx;
      logic signed [DWS-1:0] dy;
   } s1_type;

   typedef struct packed {
      logic                vld;
      logic signed [W-1:0] sx;
      logic signed [W-1:0] sy;
      logic [MCW-1:0]      mc1x;
      logic [MCW-1:0]      mc1y;
      logic [MDW-1:0]      mdx;
      logic [MDW-1:0]      mdy;
      logic                nc1x;
      logic                nc1y;
      logic                ndx;
      logic                ndy;
   } s2_type;

   typedef struct packed {
      s2_type               c;
      logic signed [PS-1:0] p;
      logic [QW-1:0]        q;
      logic [KW-1:0]        k;
   } s3_type;

   typedef struct packed {
      s2_type        c;
      logic [PW-1:0] mp;
      logic          np;
      logic [QW-1:0] q;
      logic [KW-1:0] k;
      logic          deg;
      logic          atv;
   } s4_type;

   typedef struct packed {
      logic                 vld;
      logic signed [W-1:0]  sx;
      logic signed [W-1:0]  sy;
      logic [PW-1:0]        mp;
      logic                 np;
      logic [QW-1:0]        q;
      logic                 deg;
      logic                 atv;
      logic signed [US-1:0] ux;
      logic signed [US-1:0] uy;
      logic signed [FS-1:0] fx;
      logic signed [FS-1:0] fy;
      logic [DEN-1:0]       den;
   } s5_type;

   typedef struct packed {
      logic                vld;
      logic signed [W-1:0] sx;
      logic signed [W-1:0] sy;
      logic [PW-1:0]       mp;
      logic                np;
      logic [QW-1:0]       q;
      logic                deg;
      logic                atv;
      logic [UW-1:0]       mux;
      logic [UW-1:0]       muy;
      logic                nux;
      logic                nuy;
      logic [FW-1:0]       mfx;
      logic [FW-1:0]       mfy;
      logic                nfx;
      logic                nfy;
      logic [DEN-1:0]      den;
   } s6_type;

   typedef struct packed {
      logic                vld;
      logic signed [W-1:0] sx;
      logic signed [W-1:0] sy;
      logic                deg;
      logic                atv;
   } side_type;

   logic        en;
   logic [31:0] axis_min_sq_ff;

   s1_type   s1_in, s1_ff;
   s2_type   s2_in, s2_ff;
   s2_type   s2d_ff [MUL_LATENCY];
   s3_type   s3_in, s3_ff;
   s4_type   s4_in, s4_ff;
   s4_type   s4d_ff [MUL_LATENCY];
   s5_type   s5_in, s5_ff;
   s6_type   s6_in, s6_ff;
   s6_type   s6d_ff [MUL_LATENCY];

   logic [2*MDW-1:0]   m_dxdx, m_dydy;
   logic [MDW+MCW-1:0] m_dxc1x, m_dyc1y;
   logic [2*MCW-1:0]   m_c1xc1x, m_c1yc1y;
   logic [PW+MDW-1:0]  m_pdx, m_pdy;
   logic [QW+MCW-1:0]  m_qc1x, m_qc1y;
   logic [PW+MCW-1:0]  m_pc1x, m_pc1y;
   logic [KW+MDW-1:0]  m_kdx, m_kdy;
   logic [DEN-1:0]     m_qq;
   logic [VW-1:0]      m_pux, m_puy;

   logic [NWD-1:0] dv_rem_ff [W+1][NL];
   logic [NWD-1:0] dv_rem_in [W+1][NL];
   logic [DEN-1:0] dv_den_ff [W+1][NL];
   logic [W-1:0]   dv_quo_ff [W+1][NL];
   logic [W-1:0]   dv_quo_in [W+1][NL];
   logic           dv_ovf_ff [W+1][NL];
   logic           dv_neg_ff [W+1][NL];
   side_type       dv_side_ff [W+1];
   logic [NWD-1:0] ent_num [NL];
   logic [DEN-1:0] ent_den [NL];
   logic           ent_neg [NL];

   logic [W:0]     rnd_mag_ff [NL];
   logic [W:0]     rnd_mag_in [NL];
   logic           rnd_neg_ff [NL];
   side_type       rnd_side_ff;

   logic [W-1:0]   lane_val [NL];
   logic [NL-1:0]  lane_sat;

   logic                 rsp_valid_ff;
   logic signed [W-1:0]  rsp_vx_ff, rsp_vy_ff, rsp_fx_ff, rsp_fy_ff;
   logic [1:0]           rsp_status_ff;

   // global advance: output register free or being taken
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // configuration
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_REG_AXIS_MIN_SQ) ? axis_min_sq_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_min_sq_ff <= 32'd1;
      end else if (psel && penable && pwrite && pready
                   && paddr[2] == CSR_REG_AXIS_MIN_SQ) begin
         axis_min_sq_ff <= pwdata;
      end
   end

   // stage 1: differences
   always_comb begin
      logic signed [DWS-1:0] c2x;
      logic signed [DWS-1:0] c2y;
      s1_in.vld = req_valid;
      s1_in.sx  = req_start_x;
      s1_in.sy  = req_start_y;
      s1_in.c1x = CW1'(req_mid_x) - CW1'(req_start_x);
      s1_in.c1y = CW1'(req_mid_y) - CW1'(req_start_y);
      c2x       = DWS'(req_end_x) - DWS'(req_start_x);
      c2y       = DWS'(req_end_y) - DWS'(req_start_y);
      s1_in.dx  = c2x - (DWS'(s1_in.c1x) <<< 1);
      s1_in.dy  = c2y - (DWS'(s1_in.c1y) <<< 1);
   end

   // stage 2: sign and magnitude
   always_comb begin
      logic signed [CW1-1:0] ac1x, ac1y;
      logic signed [DWS-1:0] adx, ady;
      ac1x = s1_ff.c1x[CW1-1] ? -s1_ff.c1x : s1_ff.c1x;
      ac1y = s1_ff.c1y[CW1-1] ? -s1_ff.c1y : s1_ff.c1y;
      adx  = s1_ff.dx[DWS-1]  ? -s1_ff.dx  : s1_ff.dx;
      ady  = s1_ff.dy[DWS-1]  ? -s1_ff.dy  : s1_ff.dy;
      s2_in.vld  = s1_ff.vld;
      s2_in.sx   = s1_ff.sx;
      s2_in.sy   = s1_ff.sy;
      s2_in.mc1x = ac1x[MCW-1:0];
      s2_in.mc1y = ac1y[MCW-1:0];
      s2_in.mdx  = adx[MDW-1:0];
      s2_in.mdy  = ady[MDW-1:0];
      s2_in.nc1x = s1_ff.c1x[CW1-1];
      s2_in.nc1y = s1_ff.c1y[CW1-1];
      s2_in.ndx  = s1_ff.dx[DWS-1];
      s2_in.ndy  = s1_ff.dy[DWS-1];
   end

   pvf_mul #(.A_WIDTH(MDW), .B_WIDTH(MDW)) u_mul_dxdx (
      .clock(clock), .enable(en), .a(s2_ff.mdx), .b(s2_ff.mdx), .prod(m_dxdx));
   pvf_mul #(.A_WIDTH(MDW), .B_WIDTH(MDW)) u_mul_dydy (
      .clock(clock), .enable(en), .a(s2_ff.mdy), .b(s2_ff.mdy), .prod(m_dydy));
   pvf_mul #(.A_WIDTH(MDW), .B_WIDTH(MCW)) u_mul_dxc1x (
      .clock(clock), .enable(en), .a(s2_ff.mdx), .b(s2_ff.mc1x), .prod(m_dxc1x));
   pvf_mul #(.A_WIDTH(MDW), .B_WIDTH(MCW)) u_mul_dyc1y (
      .clock(clock), .enable(en), .a(s2_ff.mdy), .b(s2_ff.mc1y), .prod(m_dyc1y));
   pvf_mul #(.A_WIDTH(MCW), .B_WIDTH(MCW)) u_mul_c1xc1x (
      .clock(clock), .enable(en), .a(s2_ff.mc1x), .b(s2_ff.mc1x), .prod(m_c1xc1x));
   pvf_mul #(.A_WIDTH(MCW), .B_WIDTH(MCW)) u_mul_c1yc1y (
      .clock(clock), .enable(en), .a(s2_ff.mc1y), .b(s2_ff.mc1y), .prod(m_c1yc1y));

   // stage 3: p = d.c1, q = |d|^2, k = |c1|^2
   always_comb begin
      logic signed [PS-1:0] tx, ty;
      tx = $signed(PS'(m_dxc1x));
      ty = $signed(PS'(m_dyc1y));
      s3_in.c = s2d_ff[MUL_LATENCY-1];
      s3_in.p = ((s3_in.c.ndx ^ s3_in.c.nc1x) ? -tx : tx)
              + ((s3_in.c.ndy ^ s3_in.c.nc1y) ? -ty : ty);
      s3_in.q = QW'(m_dxdx) + QW'(m_dydy);
      s3_in.k = KW'(m_c1xc1x) + KW'(m_c1yc1y);
   end

   // stage 4: |p|, degenerate axis, end at vertex
   always_comb begin
      logic signed [PS-1:0] ap;
      logic [TW-1:0]        lhs, rhs;
      logic signed [AS-1:0] pq;
      ap  = s3_ff.p[PS-1] ? -s3_ff.p : s3_ff.p;
      lhs = TW'(s3_ff.q) << 32;
      rhs = TW'(axis_min_sq_ff) << (2*FRAC_BITS + 2);
      pq  = AS'(s3_ff.p) + $signed(AS'(s3_ff.q));
      s4_in.c   = s3_ff.c;
      s4_in.mp  = ap[PW-1:0];
      s4_in.np  = s3_ff.p[PS-1];
      s4_in.q   = s3_ff.q;
      s4_in.k   = s3_ff.k;
      s4_in.deg = (s3_ff.q == '0) || (lhs < rhs);
      s4_in.atv = (pq == '0);
   end

   pvf_mul #(.A_WIDTH(PW), .B_WIDTH(MDW)) u_mul_pdx (
      .clock(clock), .enable(en), .a(s4_ff.mp), .b(s4_ff.c.mdx), .prod(m_pdx));
   pvf_mul #(.A_WIDTH(PW), .B_WIDTH(MDW)) u_mul_pdy (
      .clock(clock), .enable(en), .a(s4_ff.mp), .b(s4_ff.c.mdy), .prod(m_pdy));
   pvf_mul #(.A_WIDTH(QW), .B_WIDTH(MCW)) u_mul_qc1x (
      .clock(clock), .enable(en), .a(s4_ff.q), .b(s4_ff.c.mc1x), .prod(m_qc1x));
   pvf_mul #(.A_WIDTH(QW), .B_WIDTH(MCW)) u_mul_qc1y (
      .clock(clock), .enable(en), .a(s4_ff.q), .b(s4_ff.c.mc1y), .prod(m_qc1y));
   pvf_mul #(.A_WIDTH(PW), .B_WIDTH(MCW)) u_mul_pc1x (
      .clock(clock), .enable(en), .a(s4_ff.mp), .b(s4_ff.c.mc1x), .prod(m_pc1x));
   pvf_mul #(.A_WIDTH(PW), .B_WIDTH(MCW)) u_mul_pc1y (
      .clock(clock), .enable(en), .a(s4_ff.mp), .b(s4_ff.c.mc1y), .prod(m_pc1y));
   pvf_mul #(.A_WIDTH(KW), .B_WIDTH(MDW)) u_mul_kdx (
      .clock(clock), .enable(en), .a(s4_ff.k), .b(s4_ff.c.mdx), .prod(m_kdx));
   pvf_mul #(.A_WIDTH(KW), .B_WIDTH(MDW)) u_mul_kdy (
      .clock(clock), .enable(en), .a(s4_ff.k), .b(s4_ff.c.mdy), .prod(m_kdy));
   pvf_mul #(.A_WIDTH(QW), .B_WIDTH(QW)) u_mul_qq (
      .clock(clock), .enable(en), .a(s4_ff.q), .b(s4_ff.q), .prod(m_qq));

   // stage 5: u = p*d - 2q*c1 (vertex = p*u/q^2), f = k*d - 2p*c1 (focus = f/q)
   always_comb begin
      s4_type                c;
      logic signed [US-1:0]  a1x, a1y, a2x, a2y;
      logic signed [FS-1:0]  b1x, b1y, b2x, b2y;
      c   = s4d_ff[MUL_LATENCY-1];
      a1x = $signed(US'(m_pdx));
      a1y = $signed(US'(m_pdy));
      a2x = $signed(US'(m_qc1x)) <<< 1;
      a2y = $signed(US'(m_qc1y)) <<< 1;
      b1x = $signed(FS'(m_kdx));
      b1y = $signed(FS'(m_kdy));
      b2x = $signed(FS'(m_pc1x)) <<< 1;
      b2y = $signed(FS'(m_pc1y)) <<< 1;
      s5_in.vld = c.c.vld;
      s5_in.sx  = c.c.sx;
      s5_in.sy  = c.c.sy;
      s5_in.mp  = c.mp;
      s5_in.np  = c.np;
      s5_in.q   = c.q;
      s5_in.deg = c.deg;
      s5_in.atv = c.atv;
      s5_in.ux  = ((c.np ^ c.c.ndx) ? -a1x : a1x) - (c.c.nc1x ? -a2x : a2x);
      s5_in.uy  = ((c.np ^ c.c.ndy) ? -a1y : a1y) - (c.c.nc1y ? -a2y : a2y);
      s5_in.fx  = (c.c.ndx ? -b1x : b1x) - ((c.np ^ c.c.nc1x) ? -b2x : b2x);
      s5_in.fy  = (c.c.ndy ? -b1y : b1y) - ((c.np ^ c.c.nc1y) ? -b2y : b2y);
      s5_in.den = m_qq;
   end

   // stage 6: magnitudes of u and f
   always_comb begin
      logic signed [US-1:0] aux, auy;
      logic signed [FS-1:0] afx, afy;
      aux = s5_ff.ux[US-1] ? -s5_ff.ux : s5_ff.ux;
      auy = s5_ff.uy[US-1] ? -s5_ff.uy : s5_ff.uy;
      afx = s5_ff.fx[FS-1] ? -s5_ff.fx : s5_ff.fx;
      afy = s5_ff.fy[FS-1] ? -s5_ff.fy : s5_ff.fy;
      s6_in.vld = s5_ff.vld;
      s6_in.sx  = s5_ff.sx;
      s6_in.sy  = s5_ff.sy;
      s6_in.mp  = s5_ff.mp;
      s6_in.np  = s5_ff.np;
      s6_in.q   = s5_ff.q;
      s6_in.deg = s5_ff.deg;
      s6_in.atv = s5_ff.atv;
      s6_in.mux = aux[UW-1:0];
      s6_in.muy = auy[UW-1:0];
      s6_in.nux = s5_ff.ux[US-1];
      s6_in.nuy = s5_ff.uy[US-1];
      s6_in.mfx = afx[FW-1:0];
      s6_in.mfy = afy[FW-1:0];
      s6_in.nfx = s5_ff.fx[FS-1];
      s6_in.nfy = s5_ff.fy[FS-1];
      s6_in.den = s5_ff.den;
   end

   pvf_mul #(.A_WIDTH(PW), .B_WIDTH(UW)) u_mul_pux (
      .clock(clock), .enable(en), .a(s6_ff.mp), .b(s6_ff.mux), .prod(m_pux));
   pvf_mul #(.A_WIDTH(PW), .B_WIDTH(UW)) u_mul_puy (
      .clock(clock), .enable(en), .a(s6_ff.mp), .b(s6_ff.muy), .prod(m_puy));

   // divider entry: lanes are vertex x, vertex y, focus x, focus y
   always_comb begin
      s6_type c;
      c = s6d_ff[MUL_LATENCY-1];
      ent_num[0] = NWD'(m_pux);
      ent_num[1] = NWD'(m_puy);
      ent_num[2] = NWD'(c.mfx);
      ent_num[3] = NWD'(c.mfy);
      ent_den[0] = c.den;
      ent_den[1] = c.den;
      ent_den[2] = DEN'(c.q);
      ent_den[3] = DEN'(c.q);
      ent_neg[0] = c.np ^ c.nux;
      ent_neg[1] = c.np ^ c.nuy;
      ent_neg[2] = c.nfx;
      ent_neg[3] = c.nfy;
   end

   // one restoring step per stage, quotient bit W-j at stage j
   always_comb begin
      logic [NWD-1:0] sub;
      logic           ge;
      for (int ln = 0; ln < NL; ln++) begin
         dv_rem_in[0][ln] = ent_num[ln];
         dv_quo_in[0][ln] = '0;
      end
      for (int j = 1; j <= W; j++) begin
         for (int ln = 0; ln < NL; ln++) begin
            sub = NWD'(dv_den_ff[j-1][ln]) << (W - j);
            ge  = dv_rem_ff[j-1][ln] >= sub;
            dv_rem_in[j][ln] = ge ? dv_rem_ff[j-1][ln] - sub : dv_rem_ff[j-1][ln];
            dv_quo_in[j][ln] = dv_quo_ff[j-1][ln] | (W'(ge) << (W - j));
         end
      end
      for (int ln = 0; ln < NL; ln++) begin
         if (dv_ovf_ff[W][ln]) begin
            rnd_mag_in[ln] = (W+1)'(1) << W;
         end else begin
            rnd_mag_in[ln] = (W+1)'(dv_quo_ff[W][ln])
                           + (W+1)'((NWD'(dv_rem_ff[W][ln]) << 1)
                                    >= NWD'(dv_den_ff[W][ln]));
         end
      end
   end

   // apply sign, add start point, clamp
   always_comb begin
      logic signed [FV-1:0] sm, tot;
      for (int ln = 0; ln < NL; ln++) begin
         sm  = $signed(FV'(rnd_mag_ff[ln]));
         tot = (rnd_neg_ff[ln] ? -sm : sm)
             + FV'(ln[0] ? rnd_side_ff.sy : rnd_side_ff.sx);
         lane_sat[ln] = (tot > SAT_HI) || (tot < SAT_LO);
         if (tot > SAT_HI) begin
            lane_val[ln] = SAT_HI[W-1:0];
         end else if (tot < SAT_LO) begin
            lane_val[ln] = SAT_LO[W-1:0];
         end else begin
            lane_val[ln] = tot[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
         for (int i = 0; i < MUL_LATENCY; i++) begin
            s2d_ff[i].vld   <= 1'b0;
            s4d_ff[i].c.vld <= 1'b0;
            s6d_ff[i].vld   <= 1'b0;
         end
         s3_ff.c.vld <= 1'b0;
         s4_ff.c.vld <= 1'b0;
         s5_ff.vld   <= 1'b0;
         s6_ff.vld   <= 1'b0;
         for (int j = 0; j <= W; j++) begin
            dv_side_ff[j].vld <= 1'b0;
         end
         rnd_side_ff.vld <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else if (en) begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         s2d_ff[0] <= s2_ff;
         s4d_ff[0] <= s4_ff;
         s6d_ff[0] <= s6_ff;
         for (int i = 1; i < MUL_LATENCY; i++) begin
            s2d_ff[i] <= s2d_ff[i-1];
            s4d_ff[i] <= s4d_ff[i-1];
            s6d_ff[i] <= s6d_ff[i-1];
         end
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;

         dv_side_ff[0].vld <= s6d_ff[MUL_LATENCY-1].vld;
         dv_side_ff[0].sx  <= s6d_ff[MUL_LATENCY-1].sx;
         dv_side_ff[0].sy  <= s6d_ff[MUL_LATENCY-1].sy;
         dv_side_ff[0].deg <= s6d_ff[MUL_LATENCY-1].deg;
         dv_side_ff[0].atv <= s6d_ff[MUL_LATENCY-1].atv;
         for (int ln = 0; ln < NL; ln++) begin
            dv_rem_ff[0][ln] <= dv_rem_in[0][ln];
            dv_quo_ff[0][ln] <= dv_quo_in[0][ln];
            dv_den_ff[0][ln] <= ent_den[ln];
            dv_neg_ff[0][ln] <= ent_neg[ln];
            dv_ovf_ff[0][ln] <= ent_num[ln] >= (NWD'(ent_den[ln]) << W);
         end
         for (int j = 1; j <= W; j++) begin
            dv_side_ff[j] <= dv_side_ff[j-1];
            for (int ln = 0; ln < NL; ln++) begin
               dv_rem_ff[j][ln] <= dv_rem_in[j][ln];
               dv_quo_ff[j][ln] <= dv_quo_in[j][ln];
               dv_den_ff[j][ln] <= dv_den_ff[j-1][ln];
               dv_neg_ff[j][ln] <= dv_neg_ff[j-1][ln];
               dv_ovf_ff[j][ln] <= dv_ovf_ff[j-1][ln];
            end
         end

         rnd_side_ff <= dv_side_ff[W];
         for (int ln = 0; ln < NL; ln++) begin
            rnd_mag_ff[ln] <= rnd_mag_in[ln];
            rnd_neg_ff[ln] <= dv_neg_ff[W][ln];
         end

         rsp_valid_ff <= rnd_side_ff.vld;
         if (rnd_side_ff.deg) begin
            rsp_vx_ff     <= '0;
            rsp_vy_ff     <= '0;
            rsp_fx_ff     <= '0;
            rsp_fy_ff     <= '0;
            rsp_status_ff <= STATUS_DEGEN;
         end else if (rnd_side_ff.atv) begin
            rsp_vx_ff     <= lane_val[0];
            rsp_vy_ff     <= lane_val[1];
            rsp_fx_ff     <= lane_val[0];
            rsp_fy_ff     <= lane_val[1];
            rsp_status_ff <= STATUS_AT_VERTEX;
         end else begin
            rsp_vx_ff     <= lane_val[0];
            rsp_vy_ff     <= lane_val[1];
            rsp_fx_ff     <= lane_val[2];
            rsp_fy_ff     <= lane_val[3];
            rsp_status_ff <= (lane_sat != '0) ? STATUS_SAT : STATUS_OK;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_vertex_x = rsp_vx_ff;
   assign rsp_vertex_y = rsp_vy_ff;
   assign rsp_focus_x  = rsp_fx_ff;
   assign rsp_focus_y  = rsp_fy_ff;
   assign rsp_status   = rsp_status_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DEGEN |->
         rsp_vertex_x == '0 && rsp_vertex_y == '0 && rsp_focus_x == '0 && rsp_focus_y == '0)
      else $error("degenerate word carries nonzero coordinates");

   a_vertex_focus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_AT_VERTEX |->
         rsp_focus_x == rsp_vertex_x && rsp_focus_y == rsp_vertex_y)
      else $error("end-at-vertex word has focus apart from vertex");

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && req_stall == rsp_stall)
      else $error("stalled output dropped or input stall out of step");

endmodule
